// ===== hdl/potqt_pkg.sv =====
// Shared types and constants for the periodic and queued one-shot timer.
// Holds the command codes, the decoded request type and ring index helpers.
// No dependencies.
package potqt_pkg;

  localparam int AMOUNT_W    = 32;
  localparam int DELAY_W     = 16;
  localparam int PEND_W      = 3;
  localparam int TAG_BITS    = 8;
  localparam int RING_SLOTS  = 8;
  localparam int RING_IDX_W  = $clog2(RING_SLOTS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = QUEUE_IDX_W + 1;

  localparam logic [RING_IDX_W-1:0] RING_LAST = RING_IDX_W'(RING_SLOTS - 1);
  localparam logic [QUEUE_IDX_W-1:0] QUEUE_LAST = QUEUE_IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_START   = 2'd1,
    CMD_SET     = 2'd2,
    CMD_REQUEST = 2'd3
  } cmd_e;

  // Decoded request as it travels from the front end to the execution side
  typedef struct packed {
    cmd_e                  cmd;
    logic [AMOUNT_W-1:0]   amount;
    logic [DELAY_W-1:0]    limit;
    logic [TAG_BITS-1:0]   tag;
  } item_t;

  // Queue status seen by the front end and the back end
  typedef struct packed {
    logic  full;
    logic  nonempty;
  } queue_stat_t;

  function automatic logic [RING_IDX_W-1:0] ring_next(input logic [RING_IDX_W-1:0] idx);
    logic [RING_IDX_W-1:0] nxt;
    if (idx == RING_LAST) begin
      nxt = '0;
    end else begin
      nxt = idx + RING_IDX_W'(1);
    end
    return nxt;
  endfunction

  function automatic logic [RING_IDX_W-1:0] ring_pending(
      input logic [RING_IDX_W-1:0] head,
      input logic [RING_IDX_W-1:0] tail);
    logic [RING_IDX_W:0] diff;
    if (tail >= head) begin
      diff = {1'b0, tail} - {1'b0, head};
    end else begin
      diff = {1'b0, tail} + (RING_IDX_W + 1)'(RING_SLOTS) - {1'b0, head};
    end
    return diff[RING_IDX_W-1:0];
  endfunction

endpackage

// ===== hdl/periodic_and_queued_oneshot_timer_unit.sv =====
// Periodic and queued one-shot timer, top level.
// Instantiates potqt_front, potqt_queue and potqt_back; uses potqt_pkg.
//
// Usage:
//   Requests enter on in_valid_i / in_stall_o with command_i, amount_i and
//   tag_i. Command 0 is a timer tick, 1 starts the periodic timer, 2 sets
//   its period, 3 asks for a one-shot. Every request gives exactly one
//   result on out_valid_o / out_stall_i, in request order.
//   A request passes through the decode register and the queue into the
//   execute stage, which registers its result.
//   Throughput: one request per cycle while in_stall_o is low; every command,
//   ticks included, is done in a single pass of the execute stage.
//   A four-entry queue sits between decode and execute. When the receiver
//   stalls, the result is held, execute stops taking requests, the queue
//   fills and in_stall_o rises once the queue is full with a request still
//   staged in decode.
//   Reset clears both timers, the pending ring pointers and all valids;
//   the ring contents are not cleared and no clearing pass is needed.
module periodic_and_queued_oneshot_timer_unit import potqt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           command_i,
  input  logic [AMOUNT_W-1:0]  amount_i,
  input  logic [TAG_BITS-1:0]  tag_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 periodic_fired_o,
  output logic                 oneshot_fired_o,
  output logic [TAG_BITS-1:0]  fired_tag_o,
  output logic                 request_dropped_o,
  output logic                 oneshot_busy_o,
  output logic [PEND_W-1:0]    pending_count_o
);

  queue_stat_t q_stat;
  logic        push, pop;
  item_t       push_item, pop_item;

  potqt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .amount_i   (amount_i),
    .tag_i      (tag_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .item_o     (push_item)
  );

  potqt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .stat_o      (q_stat)
  );

  potqt_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_stat_i          (q_stat),
    .item_i            (pop_item),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .periodic_fired_o  (periodic_fired_o),
    .oneshot_fired_o   (oneshot_fired_o),
    .fired_tag_o       (fired_tag_o),
    .request_dropped_o (request_dropped_o),
    .oneshot_busy_o    (oneshot_busy_o),
    .pending_count_o   (pending_count_o)
  );

endmodule

// ===== hdl/potqt_front.sv =====
// Front end of the timer: takes requests, decodes the command and
// precomputes the one-shot limit. Depends on potqt_pkg.
module potqt_front import potqt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           command_i,
  input  logic [AMOUNT_W-1:0]  amount_i,
  input  logic [TAG_BITS-1:0]  tag_i,
  input  queue_stat_t          q_stat_i,
  output logic                 push_o,
  output item_t                item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  accept;

  // Stall only while the staged request cannot move into the queue
  assign push_o     = valid_q && !q_stat_i.full;
  assign in_stall_o = valid_q && q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign item_o     = item_q;

  // Decode the incoming request
  always_comb begin
    item_d.cmd    = cmd_e'(command_i);
    item_d.amount = amount_i;
    item_d.limit  = amount_i[DELAY_W-1:0] - DELAY_W'(1);
    item_d.tag    = tag_i;
  end

  // Advance or drain the staging register
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== hdl/potqt_queue.sv =====
// Short request queue between the front end and the timer back end.
// Depends on potqt_pkg.
module potqt_queue import potqt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  item_t       push_item_i,
  input  logic        pop_i,
  output item_t       pop_item_o,
  output queue_stat_t stat_o
);

  item_t                  slots_q [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;

  assign stat_o.full     = (cnt_q == QUEUE_FULL);
  assign stat_o.nonempty = (cnt_q != '0);
  assign pop_item_o      = slots_q[rd_q];

  // Advance pointers and occupancy
  always_comb begin
    rd_d  = rd_q;
    wr_d  = wr_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QUEUE_LAST) ? '0 : wr_q + QUEUE_IDX_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == QUEUE_LAST) ? '0 : rd_q + QUEUE_IDX_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QUEUE_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_item_i;
    end
  end

endmodule

// ===== hdl/potqt_back.sv =====
// Back end of the timer: periodic counter, one-shot counter, pending ring
// and the result register. Depends on potqt_pkg.
module potqt_back import potqt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  queue_stat_t          q_stat_i,
  input  item_t                item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 periodic_fired_o,
  output logic                 oneshot_fired_o,
  output logic [TAG_BITS-1:0]  fired_tag_o,
  output logic                 request_dropped_o,
  output logic                 oneshot_busy_o,
  output logic [PEND_W-1:0]    pending_count_o
);

  // Timer state
  logic [AMOUNT_W-1:0]   p_count_q, p_count_d;
  logic [AMOUNT_W-1:0]   p_reload_q, p_reload_d;
  logic                  p_on_q, p_on_d;
  logic [DELAY_W-1:0]    os_count_q, os_count_d;
  logic [DELAY_W-1:0]    os_limit_q, os_limit_d;
  logic                  os_active_q, os_active_d;
  logic [TAG_BITS-1:0]   cur_tag_q, cur_tag_d;
  logic [RING_IDX_W-1:0] head_q, head_d, tail_q, tail_d;

  // Pending ring storage
  logic [DELAY_W-1:0]    ring_limit_q [RING_SLOTS];
  logic [TAG_BITS-1:0]   ring_tag_q   [RING_SLOTS];
  logic                  ring_wr;

  // Result register
  logic                  out_valid_q, out_valid_d;
  logic                  pf_q, pf_d;
  logic                  of_q, of_d;
  logic [TAG_BITS-1:0]   ftag_q, ftag_d;
  logic                  drop_q, drop_d;
  logic                  busy_q;
  logic [PEND_W-1:0]     pend_q, pend_d;

  // Take the next request whenever the result register is free or draining
  assign pop_o = q_stat_i.nonempty && (!out_valid_q || !out_stall_i);

  // Execute one request
  always_comb begin
    p_count_d   = p_count_q;
    p_reload_d  = p_reload_q;
    p_on_d      = p_on_q;
    os_count_d  = os_count_q;
    os_limit_d  = os_limit_q;
    os_active_d = os_active_q;
    cur_tag_d   = cur_tag_q;
    head_d      = head_q;
    tail_d      = tail_q;
    ring_wr     = 1'b0;
    pf_d        = 1'b0;
    of_d        = 1'b0;
    ftag_d      = '0;
    drop_d      = 1'b0;
    case (item_i.cmd)
      CMD_TICK: begin
        if (p_on_q && (p_reload_q != '0)) begin
          if (p_count_q >= p_reload_q) begin
            p_count_d = '0;
            pf_d      = 1'b1;
          end else begin
            p_count_d = p_count_q + AMOUNT_W'(1);
          end
        end
        if (os_active_q) begin
          if (os_count_q >= os_limit_q) begin
            of_d        = 1'b1;
            ftag_d      = cur_tag_q;
            os_active_d = 1'b0;
            cur_tag_d   = '0;
            // Start the oldest waiting one-shot at once
            if (head_q != tail_q) begin
              os_limit_d  = ring_limit_q[head_q];
              cur_tag_d   = ring_tag_q[head_q];
              os_count_d  = '0;
              os_active_d = 1'b1;
              head_d      = ring_next(head_q);
            end
          end else begin
            os_count_d = os_count_q + DELAY_W'(1);
          end
        end
      end
      CMD_START: begin
        p_reload_d = item_i.amount;
        p_count_d  = '0;
        p_on_d     = 1'b1;
      end
      CMD_SET: begin
        p_reload_d = item_i.amount;
        p_count_d  = '0;
      end
      CMD_REQUEST: begin
        if (!os_active_q) begin
          os_limit_d  = item_i.limit;
          os_count_d  = '0;
          os_active_d = 1'b1;
          cur_tag_d   = item_i.tag;
        end else if (ring_next(tail_q) == head_q) begin
          drop_d = 1'b1;
        end else begin
          ring_wr = 1'b1;
          tail_d  = ring_next(tail_q);
        end
      end
      default: begin
      end
    endcase
    pend_d = PEND_W'(ring_pending(head_d, tail_d));
  end

  // Hold the result until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_count_q   <= '0;
      p_reload_q  <= '0;
      p_on_q      <= 1'b0;
      os_count_q  <= '0;
      os_limit_q  <= '0;
      os_active_q <= 1'b0;
      cur_tag_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        p_count_q   <= p_count_d;
        p_reload_q  <= p_reload_d;
        p_on_q      <= p_on_d;
        os_count_q  <= os_count_d;
        os_limit_q  <= os_limit_d;
        os_active_q <= os_active_d;
        cur_tag_q   <= cur_tag_d;
        head_q      <= head_d;
        tail_q      <= tail_d;
      end
    end
  end

  // Write a waiting one-shot into the ring
  always_ff @(posedge clk_i) begin
    if (pop_o && ring_wr) begin
      ring_limit_q[tail_q] <= item_i.limit;
      ring_tag_q[tail_q]   <= item_i.tag;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pf_q   <= pf_d;
      of_q   <= of_d;
      ftag_q <= ftag_d;
      drop_q <= drop_d;
      busy_q <= os_active_d;
      pend_q <= pend_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign periodic_fired_o  = pf_q;
  assign oneshot_fired_o   = of_q;
  assign fired_tag_o       = ftag_q;
  assign request_dropped_o = drop_q;
  assign oneshot_busy_o    = busy_q;
  assign pending_count_o   = pend_q;

endmodule

// ===== tb/tb_periodic_and_queued_oneshot_timer_unit.sv =====
// Self-checking testbench for periodic_and_queued_oneshot_timer_unit.
// Drives a directed table and random requests, predicts every result in-line.
// Depends on potqt_pkg and the timer unit RTL only.
module tb_periodic_and_queued_oneshot_timer_unit import potqt_pkg::*; ();

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 40;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic                periodic_fired;
    logic                oneshot_fired;
    logic [TAG_BITS-1:0] fired_tag;
    logic                request_dropped;
    logic                oneshot_busy;
    logic [PEND_W-1:0]   pending_count;
  } timer_result_t;

  typedef struct {
    cmd_e                cmd;
    logic [AMOUNT_W-1:0] amount;
    logic [TAG_BITS-1:0] tag;
    bit                  typed;
    timer_result_t       want;
  } step_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          command_i;
  logic [AMOUNT_W-1:0] amount_i;
  logic [TAG_BITS-1:0] tag_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                periodic_fired_o;
  logic                oneshot_fired_o;
  logic [TAG_BITS-1:0] fired_tag_o;
  logic                request_dropped_o;
  logic                oneshot_busy_o;
  logic [PEND_W-1:0]   pending_count_o;

  // Predicted timer state
  logic [AMOUNT_W-1:0]   per_count, per_reload;
  logic                  per_on;
  logic [DELAY_W-1:0]    os_count, os_limit;
  logic                  os_active;
  logic [TAG_BITS-1:0]   os_tag;
  logic [DELAY_W-1:0]    ring_delay [RING_SLOTS];
  logic [TAG_BITS-1:0]   ring_tag   [RING_SLOTS];
  logic [RING_IDX_W-1:0] ring_rd, ring_wr;

  timer_result_t expected_results [$];
  step_row_t     directed_rows [$];

  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  logic hold_go = 1'b0;
  int  hold_count = 0;
  int  cycle_count = 0;
  int  fail_count = 0;
  int  sent_count = 0;
  int  checked_count = 0;
  int  periodic_seen = 0;
  int  oneshot_seen = 0;
  int  dropped_seen = 0;
  int  in_stall_cycles = 0;

  periodic_and_queued_oneshot_timer_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .amount_i         (amount_i),
    .tag_i            (tag_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .periodic_fired_o (periodic_fired_o),
    .oneshot_fired_o  (oneshot_fired_o),
    .fired_tag_o      (fired_tag_o),
    .request_dropped_o(request_dropped_o),
    .oneshot_busy_o   (oneshot_busy_o),
    .pending_count_o  (pending_count_o)
  );

  // Generate the clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Load a one-shot into the running slot
  function automatic void oneshot_load(logic [DELAY_W-1:0] delay, logic [TAG_BITS-1:0] tag);
    os_limit  = delay - DELAY_W'(1);
    os_count  = '0;
    os_active = 1'b1;
    os_tag    = tag;
  endfunction

  // Advance the predicted timers by one request and return its result
  function automatic timer_result_t timer_predict(cmd_e cmd, logic [AMOUNT_W-1:0] amount,
                                                  logic [TAG_BITS-1:0] tag);
    timer_result_t res;
    logic [RING_IDX_W-1:0] wr_next;
    res = '0;
    case (cmd)
      CMD_TICK: begin
        if (per_on && per_reload != '0) begin
          if (per_count >= per_reload) begin
            per_count = '0;
            res.periodic_fired = 1'b1;
          end else begin
            per_count = per_count + AMOUNT_W'(1);
          end
        end
        if (os_active) begin
          if (os_count >= os_limit) begin
            res.oneshot_fired = 1'b1;
            res.fired_tag     = os_tag;
            os_active = 1'b0;
            os_tag    = '0;
            if (ring_rd != ring_wr) begin
              oneshot_load(ring_delay[ring_rd], ring_tag[ring_rd]);
              ring_rd = RING_IDX_W'((int'(ring_rd) + 1) % RING_SLOTS);
            end
          end else begin
            os_count = os_count + DELAY_W'(1);
          end
        end
      end
      CMD_START: begin
        per_reload = amount;
        per_count  = '0;
        per_on     = 1'b1;
      end
      CMD_SET: begin
        per_reload = amount;
        per_count  = '0;
      end
      default: begin
        if (!os_active) begin
          oneshot_load(amount[DELAY_W-1:0], tag);
        end else begin
          wr_next = RING_IDX_W'((int'(ring_wr) + 1) % RING_SLOTS);
          if (wr_next == ring_rd) begin
            res.request_dropped = 1'b1;
          end else begin
            ring_delay[ring_wr] = amount[DELAY_W-1:0];
            ring_tag[ring_wr]   = tag;
            ring_wr = wr_next;
          end
        end
      end
    endcase
    res.oneshot_busy  = os_active;
    res.pending_count = PEND_W'((int'(ring_wr) + RING_SLOTS - int'(ring_rd)) % RING_SLOTS);
    return res;
  endfunction

  function automatic step_row_t step_row(cmd_e c, logic [AMOUNT_W-1:0] a,
                                         logic [TAG_BITS-1:0] t, bit typed = 1'b0,
                                         timer_result_t w = '0);
    step_row_t r;
    r.cmd = c; r.amount = a; r.tag = t; r.typed = typed; r.want = w;
    return r;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR @%0d: %s", cycle_count, msg);
  endtask

  // Offer one request, hold it until taken, then record its expected result
  task automatic send_request(cmd_e cmd, logic [AMOUNT_W-1:0] amount, logic [TAG_BITS-1:0] tag,
                              bit typed = 1'b0, timer_result_t typed_result = '0);
    timer_result_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    amount_i   <= amount;
    tag_i      <= tag;
    do @(posedge clk_i); while (in_stall_o);
    pred = timer_predict(cmd, amount, tag);
    expected_results.push_back(typed ? typed_result : pred);
    sent_count++;
  endtask

  // Mostly ticks with requests and short periods mixed in; full-width values now and then
  task automatic send_random(int n);
    cmd_e                cmd;
    logic [AMOUNT_W-1:0] amt;
    int                  r;
    for (int i = 0; i < n; i++) begin
      r   = $urandom_range(99);
      amt = $urandom();
      if (r < 70) begin
        cmd = CMD_TICK;
      end else if (r < 76) begin
        cmd = CMD_START;
      end else if (r < 82) begin
        cmd = CMD_SET;
      end else begin
        cmd = CMD_REQUEST;
      end
      if ((cmd == CMD_START || cmd == CMD_SET) && $urandom_range(15) != 0) begin
        amt = AMOUNT_W'($urandom_range(12));
      end
      if (cmd == CMD_REQUEST) begin
        amt[DELAY_W-1:0] = DELAY_W'($urandom_range(24, 1));
      end
      send_request(cmd, amt, TAG_BITS'($urandom_range(255)));
    end
  endtask

  // Drive the result stall: a long hold-off once asked, random idling otherwise
  always @(posedge clk_i) begin
    if (hold_go && hold_count < HOLD_CYCLES) begin
      hold_count  <= hold_count + 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Check each taken result against the oldest expectation
  always @(posedge clk_i) begin : result_check
    timer_result_t got, want;
    if (rst_ni && in_valid_i && in_stall_o) in_stall_cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {periodic_fired_o, oneshot_fired_o, fired_tag_o, request_dropped_o,
             oneshot_busy_o, pending_count_o};
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result %h", got));
      end else begin
        want = expected_results.pop_front();
        checked_count++;
        if (got !== want) begin
          note_failure($sformatf(
            "pfire %b/%b ofire %b/%b tag %h/%h drop %b/%b busy %b/%b pend %0d/%0d (exp/act)",
            want.periodic_fired, got.periodic_fired, want.oneshot_fired, got.oneshot_fired,
            want.fired_tag, got.fired_tag, want.request_dropped, got.request_dropped,
            want.oneshot_busy, got.oneshot_busy, want.pending_count, got.pending_count));
        end
        periodic_seen += got.periodic_fired;
        oneshot_seen  += got.oneshot_fired;
        dropped_seen  += got.request_dropped;
      end
    end
  end

  // End the run as failed once the cycle counter reaches CYCLE_LIMIT
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    command_i  = CMD_TICK;
    amount_i   = '0;
    tag_i      = '0;
    per_count = '0; per_reload = '0; per_on = 1'b0;
    os_count = '0; os_limit = '0; os_active = 1'b0; os_tag = '0;
    ring_rd = '0; ring_wr = '0;

    // Directed table; typed results only where obvious
    directed_rows.push_back(step_row(CMD_TICK, 32'h0, 8'h00, 1'b1, '0));
    directed_rows.push_back(step_row(CMD_REQUEST, 32'h1, 8'hFF, 1'b1,
                            timer_result_t'({2'b00, 8'h00, 2'b01, 3'd0})));
    directed_rows.push_back(step_row(CMD_TICK, 32'hFFFF_FFFF, 8'hFF, 1'b1,
                            timer_result_t'({2'b01, 8'hFF, 2'b00, 3'd0})));
    directed_rows.push_back(step_row(CMD_START, 32'h1, 8'h00, 1'b1, '0));
    directed_rows.push_back(step_row(CMD_TICK, 32'h0, 8'h00));
    directed_rows.push_back(step_row(CMD_TICK, 32'h0, 8'h00));
    // upper amount bits play no part in the one-shot delay
    directed_rows.push_back(step_row(CMD_REQUEST, 32'hFFFF_0004, 8'h00));
    for (int i = 0; i < RING_SLOTS - 1; i++) begin
      directed_rows.push_back(step_row(CMD_REQUEST, {16'h1234, 16'(i + 2)}, 8'(8'h55 << i)));
    end
    // full ring drops the request
    directed_rows.push_back(step_row(CMD_REQUEST, 32'hFFFF_FFFF, 8'h80, 1'b1,
                            timer_result_t'({2'b00, 8'h00, 2'b11, 3'd7})));
    directed_rows.push_back(step_row(CMD_SET, 32'hFFFF_FFFF, 8'h00, 1'b1,
                            timer_result_t'({2'b00, 8'h00, 2'b01, 3'd7})));
    directed_rows.push_back(step_row(CMD_TICK, 32'h0, 8'h00));
    directed_rows.push_back(step_row(CMD_SET, 32'h0, 8'h00, 1'b1,
                            timer_result_t'({2'b00, 8'h00, 2'b01, 3'd7})));
    directed_rows.push_back(step_row(CMD_TICK, 32'h0, 8'h00));
    directed_rows.push_back(step_row(CMD_START, 32'h3, 8'h00));
    directed_rows.push_back(step_row(CMD_TICK, 32'h0, 8'h00));

    // Hold reset, then release on a clock edge
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender idles a little, receiver a lot
    tx_idle_pct = 13;
    rx_idle_pct = 65;
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].cmd, directed_rows[i].amount, directed_rows[i].tag,
                   directed_rows[i].typed, directed_rows[i].want);
    end
    // Tick until the running one-shot and the queued ones have all expired
    while (os_active || ring_rd != ring_wr) begin
      send_request(CMD_TICK, $urandom(), TAG_BITS'($urandom_range(255)));
    end
    send_random(110);

    // Sender idles a lot, receiver a little
    tx_idle_pct = 65;
    rx_idle_pct = 13;
    send_random(110);

    // No idling, but one long receiver hold-off to back up the pipeline
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_go <= 1'b1;
    send_random(120);
    in_valid_i <= 1'b0;

    // Drain and settle
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) note_failure("results still outstanding at end");

    $display("Sent %0d requests, checked %0d results: %0d periodic, %0d one-shot, %0d dropped.",
             sent_count, checked_count, periodic_seen, oneshot_seen, dropped_seen);
    $display("Input was stalled for %0d cycles; %0d mismatches.", in_stall_cycles, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/potqt_pkg.sv
hdl/potqt_front.sv
hdl/potqt_queue.sv
hdl/potqt_back.sv
hdl/periodic_and_queued_oneshot_timer_unit.sv
tb/tb_periodic_and_queued_oneshot_timer_unit.sv
